@@ rtl/core/ptrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task release scheduler package
// Shared widths, reset values, codes and types of the scheduler core.
// ----------------------------------------------------------------------------
package ptrs_pkg;

   localparam int DEF_SLOT_COUNT = 8;
   localparam int SLOT_W         = 5;
   localparam int PERIOD_W       = 16;
   localparam int TICK_W         = 16;
   localparam int TIME_W         = 32;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 1;
   localparam int MASK_W         = 8;
   localparam int MASK_IDX_W     = 3;
   localparam int SCAN_W         = 4;
   localparam int MOD_CNT_W      = 5;

   localparam logic [TICK_W-1:0] TICK_MS_RESET        = 16'd1;
   localparam logic [TIME_W-1:0] HYPERPERIOD_MS_RESET = 32'd1000;

   // Operation codes of a request.
   localparam logic OP_REGISTER = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_MS        = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYPERPERIOD_MS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REG_CHECK,
      ST_TICK_ADDR,
      ST_TICK_DATA,
      ST_TICK_DIV,
      ST_RESP
   } state_type;

   // Status returned by the serial remainder unit.
   typedef struct packed {
      logic done;
      logic is_zero;
   } mod_result_type;

endpackage

@@ rtl/core/ptrs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ptrs_ram #(
   parameter int DATA_W = 17,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ptrs_mod.sv @@
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division, one dividend bit per cycle; reports a zero remainder.
// ----------------------------------------------------------------------------
module ptrs_mod
   import ptrs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [TIME_W-1:0]   dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output mod_result_type      result
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]    quo_ff, quo_in;
   logic [PERIOD_W:0]    rem_ff, rem_in;
   logic [PERIOD_W-1:0]  div_ff, div_in;
   logic [PERIOD_W:0]    rem_shift;

   // The remainder stays below the divisor, so the shifted value fits in 17 bits.
   assign rem_shift = {rem_ff[PERIOD_W-1:0], quo_ff[TIME_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = rem_shift - {1'b0, div_ff};
         end else begin
            rem_in = rem_shift;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MOD_CNT_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign result.done    = done_ff;
   assign result.is_zero = (rem_ff == '0);

endmodule

@@ rtl/core/periodic_task_release_scheduler.sv @@
// ----------------------------------------------------------------------------
// Periodic task release scheduler
// Cyclic executive: slot table of periodic tasks and a millisecond counter.
// ----------------------------------------------------------------------------
// A register request reads its slot, checks it and queues its answer. A tick
// request reads each scanned slot in turn and runs the serial remainder unit
// for every slot that holds a task with a nonzero period, then queues the
// answer. One request is processed at a time; the next is taken once the
// answer is queued. Reset is synchronous: table empty, time 0, tick 1 ms,
// wrap 1000 ms.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler
   import ptrs_pkg::*;
#(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [SLOT_W-1:0]      req_slot,
   input  logic [PERIOD_W-1:0]    req_period_ms,
   input  logic                   req_has_task,
   // Response channel.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [MASK_W-1:0]      rsp_fire_mask,
   output logic                   rsp_accepted,
   output logic [TIME_W-1:0]      rsp_tick_time,
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   // Only the first eight slots can show up in the fire mask, so the scan
   // stops there; releases of higher slots would have no visible effect.
   localparam int TICK_SLOTS = (SLOT_COUNT < MASK_W) ? SLOT_COUNT : MASK_W;
   localparam int ENTRY_W    = PERIOD_W + 1;

   state_type state_ff, state_in;

   // Request held for the duration of its processing.
   logic                  op_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic                  has_task_ff;
   logic                  accepted_ff, accepted_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;

   // Architectural state outside the table.
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [TICK_W-1:0]     tick_ff;
   logic [TIME_W-1:0]     hyper_ff;
   // One bit per table entry: an entry never written since reset reads as
   // an empty slot with a zero period.
   logic [SLOT_COUNT-1:0] written_ff, written_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]     rsp_mask_ff;
   logic                  rsp_accepted_ff;
   logic [TIME_W-1:0]     rsp_time_ff;
   logic                  rsp_load;

   // Table and remainder unit hookup.
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [ENTRY_W-1:0]    ram_wdata;
   logic                  ram_re;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;
   logic                  mod_start;
   mod_result_type        mod_result;

   logic [IDX_W-1:0]      slot_addr;
   logic [IDX_W-1:0]      scan_addr;
   logic                  slot_in_range;
   logic                  slot_occupied;
   logic                  entry_live;
   logic                  scan_last;
   logic                  out_free;
   logic [TIME_W-1:0]     time_sum;

   assign slot_addr     = IDX_W'(slot_ff);
   assign scan_addr     = IDX_W'(scan_ff);
   assign slot_in_range = ({1'b0, slot_ff} < (SLOT_W + 1)'(SLOT_COUNT));
   assign slot_occupied = written_ff[slot_addr] & ram_rdata[PERIOD_W];
   // A slot is a release candidate when it holds a task with a nonzero period.
   assign entry_live    = written_ff[scan_addr] & ram_rdata[PERIOD_W] &
                          (ram_rdata[PERIOD_W-1:0] != '0);
   assign scan_last     = (scan_ff == SCAN_W'(TICK_SLOTS - 1));
   assign out_free      = !rsp_valid_ff || rsp_ready;
   // The sum wraps at 2^32; only an exact hit of the hyperperiod resets time.
   assign time_sum      = time_ff + {{(TIME_W - TICK_W){1'b0}}, tick_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_TICK) ? ST_TICK_ADDR : ST_REG_CHECK;
            end
         end
         ST_REG_CHECK: begin
            state_in = ST_RESP;
         end
         ST_TICK_ADDR: begin
            state_in = ST_TICK_DATA;
         end
         ST_TICK_DATA: begin
            if (entry_live) begin
               state_in = ST_TICK_DIV;
            end else begin
               state_in = scan_last ? ST_RESP : ST_TICK_ADDR;
            end
         end
         ST_TICK_DIV: begin
            if (mod_result.done) begin
               state_in = scan_last ? ST_RESP : ST_TICK_ADDR;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs of each state.
   always_comb begin
      req_ready = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = slot_addr;
      ram_we    = 1'b0;
      mod_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // A register request reads its slot while it is being taken.
            req_ready = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(req_slot);
         end
         ST_REG_CHECK: begin
            ram_we = slot_in_range && !slot_occupied;
         end
         ST_TICK_ADDR: begin
            ram_re    = 1'b1;
            ram_raddr = scan_addr;
         end
         ST_TICK_DATA: begin
            mod_start = entry_live;
         end
         ST_TICK_DIV: begin
         end
         ST_RESP: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign ram_waddr = slot_addr;
   assign ram_wdata = {has_task_ff, period_ff};

   // Working registers of the current request.
   always_comb begin
      accepted_in  = accepted_ff;
      mask_in      = mask_ff;
      scan_in      = scan_ff;
      written_in   = written_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            accepted_in = 1'b0;
            mask_in     = '0;
            scan_in     = '0;
         end
         ST_REG_CHECK: begin
            accepted_in = ram_we;
            if (ram_we) begin
               written_in[slot_addr] = 1'b1;
            end
         end
         ST_TICK_DATA: begin
            if (!entry_live) begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_TICK_DIV: begin
            if (mod_result.done) begin
               scan_in = scan_ff + 1'b1;
               if (mod_result.is_zero) begin
                  mask_in[scan_ff[MASK_IDX_W-1:0]] = 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_TICK) begin
                  time_in = (time_sum == hyper_ff) ? '0 : time_sum;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
         time_ff      <= '0;
         tick_ff      <= TICK_MS_RESET;
         hyper_ff     <= HYPERPERIOD_MS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         written_ff   <= written_in;
         time_ff      <= time_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TICK_MS:        tick_ff  <= csr_wdata[TICK_W-1:0];
               CSR_HYPERPERIOD_MS: hyper_ff <= csr_wdata[TIME_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff       <= req_op;
         slot_ff     <= req_slot;
         period_ff   <= req_period_ms;
         has_task_ff <= req_has_task;
      end
      accepted_ff <= accepted_in;
      mask_ff     <= mask_in;
      scan_ff     <= scan_in;
      if (rsp_load) begin
         // Fields that do not belong to the request's kind read as zero.
         rsp_mask_ff     <= (op_ff == OP_TICK) ? mask_ff : '0;
         rsp_accepted_ff <= (op_ff == OP_REGISTER) ? accepted_ff : 1'b0;
         rsp_time_ff     <= (op_ff == OP_TICK) ? time_ff : '0;
      end
   end

   ptrs_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (SLOT_COUNT),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ptrs_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (time_ff),
      .divisor  (ram_rdata[PERIOD_W-1:0]),
      .result   (mod_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fire_mask = rsp_mask_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_tick_time = rsp_time_ff;

endmodule

@@ sim/periodic_task_release_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// Periodic task release scheduler testbench
// Drives register and tick requests through the valid/ready channels at
// random pace. A local copy of the slot table and time counter predicts
// every answer, and each answer is compared field by field.
// ----------------------------------------------------------------------------

// One expected answer of the scheduler.
typedef struct packed {
   logic [ptrs_pkg::MASK_W-1:0] fire_mask;
   logic                        accepted;
   logic [ptrs_pkg::TIME_W-1:0] tick_time;
} release_answer_type;

// Slot table, time counter and timer settings as the block should hold them,
// plus the answers still due from the block.
class slot_release_book_type;
   logic [ptrs_pkg::PERIOD_W-1:0] period_of [ptrs_pkg::DEF_SLOT_COUNT];
   logic                          present   [ptrs_pkg::DEF_SLOT_COUNT];
   logic [ptrs_pkg::TIME_W-1:0]   now_ms;
   logic [ptrs_pkg::TICK_W-1:0]   step_ms;
   logic [ptrs_pkg::TIME_W-1:0]   wrap_ms;
   release_answer_type            due_answers[$];
   int unsigned                   errors;
   int unsigned                   ticks;
   int unsigned                   registrations;
   int unsigned                   registrations_taken;
   int unsigned                   releases;

   function new();
      foreach (period_of[i]) begin
         period_of[i] = '0;
         present[i]   = 1'b0;
      end
      now_ms              = '0;
      step_ms             = ptrs_pkg::TICK_MS_RESET;
      wrap_ms             = ptrs_pkg::HYPERPERIOD_MS_RESET;
      errors              = 0;
      ticks               = 0;
      registrations       = 0;
      registrations_taken = 0;
      releases            = 0;
   endfunction

   function void write_register(input logic [ptrs_pkg::CSR_INDEX_W-1:0] index,
                                input logic [ptrs_pkg::CSR_DATA_W-1:0]  value);
      if (index == ptrs_pkg::CSR_TICK_MS)
         step_ms = value[ptrs_pkg::TICK_W-1:0];
      else if (index == ptrs_pkg::CSR_HYPERPERIOD_MS)
         wrap_ms = value;
   endfunction

   function int unsigned outstanding();
      return due_answers.size();
   endfunction

   function void take_request(input logic                          op,
                              input logic [ptrs_pkg::SLOT_W-1:0]   slot,
                              input logic [ptrs_pkg::PERIOD_W-1:0] period,
                              input logic                          has_task);
      release_answer_type want;
      want = '0;
      if (op == ptrs_pkg::OP_REGISTER) begin
         registrations++;
         // A slot takes a new task only while no task is present in it.
         if (int'(slot) < ptrs_pkg::DEF_SLOT_COUNT && !present[slot]) begin
            period_of[slot] = period;
            present[slot]   = has_task;
            want.accepted   = 1'b1;
            registrations_taken++;
         end
      end else begin
         ticks++;
         want.tick_time = now_ms;
         foreach (period_of[i]) begin
            if (period_of[i] != '0 && present[i] &&
                (now_ms % {16'd0, period_of[i]}) == '0 && i < ptrs_pkg::MASK_W)
               want.fire_mask[i] = 1'b1;
         end
         releases += $countones(want.fire_mask);
         now_ms = now_ms + {16'd0, step_ms};
         if (now_ms == wrap_ms)
            now_ms = '0;
      end
      due_answers.push_back(want);
   endfunction

   function void match_response(input logic [ptrs_pkg::MASK_W-1:0] fire_mask,
                                input logic                        accepted,
                                input logic [ptrs_pkg::TIME_W-1:0] tick_time,
                                input longint unsigned             stamp);
      release_answer_type want;
      if (due_answers.size() == 0) begin
         $display("%0d ns: unexpected answer, actual fire_mask %h accepted %b tick_time %0d",
                  stamp, fire_mask, accepted, tick_time);
         errors++;
         return;
      end
      want = due_answers.pop_front();
      if (want.fire_mask !== fire_mask) begin
         $display("%0d ns: fire_mask mismatch, expected %h, actual %h",
                  stamp, want.fire_mask, fire_mask);
         errors++;
      end
      if (want.accepted !== accepted) begin
         $display("%0d ns: accepted mismatch, expected %b, actual %b",
                  stamp, want.accepted, accepted);
         errors++;
      end
      if (want.tick_time !== tick_time) begin
         $display("%0d ns: tick_time mismatch, expected %0d, actual %0d",
                  stamp, want.tick_time, tick_time);
         errors++;
      end
   endfunction
endclass

module periodic_task_release_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptrs_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 6;
   // Percentage of cycles in which the answer side holds back, and of requests after which the request side does.
   localparam int IDLE_PCT     = 27;
   // Cycles without any handshake before the run is declared hung. The
   // slowest tick divides for every slot; stalls on both sides come on top.
   localparam int HANG_LIMIT   = 5000;
   // Cycles allowed after the last answer for anything stray to show up.
   localparam int TAIL_CYCLES  = 300;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic                   req_op        = OP_TICK;
   logic [SLOT_W-1:0]      req_slot      = '0;
   logic [PERIOD_W-1:0]    req_period_ms = '0;
   logic                   req_has_task  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [MASK_W-1:0]      rsp_fire_mask;
   logic                   rsp_accepted;
   logic [TIME_W-1:0]      rsp_tick_time;
   logic                   csr_we        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = CSR_TICK_MS;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;

   // While calm is set neither side idles.
   bit                     calm          = 1'b0;
   int unsigned            quiet_cycles  = 0;
   int unsigned            timelines     = 0;
   slot_release_book_type  book;

   periodic_task_release_scheduler dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_slot      (req_slot),
      .req_period_ms (req_period_ms),
      .req_has_task  (req_has_task),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_fire_mask (rsp_fire_mask),
      .rsp_accepted  (rsp_accepted),
      .rsp_tick_time (rsp_tick_time),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Answer side. Outputs are sampled at the edge, before the block updates
   // them, and rsp_ready for the next edge is decided at random unless calm is set.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.match_response(rsp_fire_mask, rsp_accepted, rsp_tick_time, $time);
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Hang detection: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == HANG_LIMIT) begin
         $display("%0d ns: no handshake for %0d cycles, giving up", $time, HANG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one request and holds it until the block takes it. Called at
   // a rising edge; returns at a rising edge. Valid is lowered only for a
   // random gap after the handshake, so a request that follows directly
   // keeps valid high without a drop.
   task automatic offer_request(input logic                op,
                                input logic [SLOT_W-1:0]   slot,
                                input logic [PERIOD_W-1:0] period,
                                input logic                has_task);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_slot      <= slot;
      req_period_ms <= period;
      req_has_task  <= has_task;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      book.take_request(op, slot, period, has_task);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1))
            @(posedge clock);
      end
   endtask

   // A tick carries random values in the fields it does not use.
   task automatic offer_tick();
      offer_request(OP_TICK, SLOT_W'($urandom_range(31)),
                    PERIOD_W'($urandom_range(65535)), 1'($urandom_range(1)));
   endtask

   // Registrations lean toward slots that exist and short periods, so that
   // the table fills and tasks fire often; the rest probe the full ranges.
   task automatic offer_registration();
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] period;
      int                  pick;
      if ($urandom_range(99) < 70)
         slot = SLOT_W'($urandom_range(DEF_SLOT_COUNT - 1));
      else
         slot = SLOT_W'($urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 15)
         period = '0;
      else if (pick < 75)
         period = PERIOD_W'($urandom_range(12, 1));
      else
         period = PERIOD_W'($urandom_range(65535));
      offer_request(OP_REGISTER, slot, period, $urandom_range(99) < 70);
   endtask

   // Brings the block to rest: no request offered and every answer in.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (book.outstanding() != 0)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
   endtask

   // One register write. The extra edge keeps the enable from being lowered
   // and raised again in the same step when writes follow each other.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      book.write_register(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Runs a stretch of random requests under one timer setting. The counter
   // is first pulled back to zero: the hyperperiod is set to exactly where
   // the next tick lands, which also exercises the exact-match wrap.
   task automatic run_timeline(input logic [TICK_W-1:0] step,
                               input logic [TIME_W-1:0] wrap_at,
                               input int                count);
      logic [15:0] junk;
      junk = 16'($urandom_range(65535));
      // The upper half of the write is ignored for the 16-bit tick size.
      write_csr(CSR_TICK_MS, {junk, step});
      write_csr(CSR_HYPERPERIOD_MS, book.now_ms + step);
      offer_tick();
      quiesce();
      write_csr(CSR_HYPERPERIOD_MS, wrap_at);
      repeat (count) begin
         if ($urandom_range(99) < 40)
            offer_registration();
         else
            offer_tick();
      end
      quiesce();
      timelines++;
   endtask

   initial begin
      book = new();
      repeat (RESET_CYCLES)
         @(posedge clock);
      reset <= 1'b0;

      // First tick at reset settings, with an empty table: time 0, no release.
      offer_tick();
      quiesce();

      // Directed requests under the reset timer values.
      write_csr(CSR_TICK_MS, 32'h0000_0001);
      write_csr(CSR_HYPERPERIOD_MS, 32'd1000);
      // Slots past the end of the table are refused, including the top one.
      offer_request(OP_REGISTER, 5'd31, 16'hFFFF, 1'b1);
      offer_request(OP_REGISTER, 5'd8, 16'd5, 1'b1);
      // A present task with period zero occupies its slot but never fires.
      offer_request(OP_REGISTER, 5'd0, 16'd0, 1'b1);
      // The slot is taken now, so this is refused.
      offer_request(OP_REGISTER, 5'd0, 16'd3, 1'b1);
      // Registered without a task: accepted, but the slot stays free.
      offer_request(OP_REGISTER, 5'd1, 16'd2, 1'b0);
      offer_tick();
      // So it can be overwritten by a real task.
      offer_request(OP_REGISTER, 5'd1, 16'd1, 1'b1);
      offer_request(OP_REGISTER, 5'd2, 16'hFFFF, 1'b1);
      offer_request(OP_REGISTER, 5'd7, 16'd3, 1'b1);
      offer_request(OP_REGISTER, 5'd4, 16'd2, 1'b1);
      // A period without a task never releases anything.
      offer_request(OP_REGISTER, 5'd5, 16'd7, 1'b0);
      repeat (6)
         offer_tick();
      quiesce();
      // A zero tick size leaves the time where it is.
      write_csr(CSR_TICK_MS, 32'h5A5A_0000);
      offer_tick();
      offer_tick();
      quiesce();

      // Random stretches under several timer settings, from the smallest to
      // the largest step and up to the largest hyperperiod.
      run_timeline(16'd1, 32'd60, 110);
      run_timeline(16'd3, 32'd3 * $urandom_range(40, 10), 100);
      calm = 1'b1;
      run_timeline(16'd2, 32'd24, 100);
      calm = 1'b0;
      run_timeline(16'hFFFF, 32'd65535 * 3, 80);
      run_timeline(TICK_W'($urandom_range(16, 1)), 32'hFFFF_FFFF, 80);
      // A hyperperiod the step cannot hit: the counter runs on past it.
      run_timeline(16'd2, 32'd7, 40);

      repeat (TAIL_CYCLES)
         @(posedge clock);
      $display("Covered %0d ticks and %0d registrations (%0d taken) over %0d timer settings,",
               book.ticks, book.registrations, book.registrations_taken, timelines);
      $display("with %0d slot releases and an exact hyperperiod wrap under each setting.",
               book.releases);
      if (book.errors == 0 && book.outstanding() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
